FILE: hdl/srrip_pkg.sv
`timescale 1ns / 1ps

package srrip_pkg;

   localparam int DEF_NUM_SETS  = 2048;
   localparam int DEF_NUM_WAYS  = 16;
   localparam int DEF_SIG_BITS  = 12;
   localparam int DEF_ADDR_BITS = 48;

   localparam int SET_FIELD_W = 11;
   localparam int WAY_FIELD_W = 4;
   localparam int VICTIM_W    = 4;
   localparam int MAX_WAY_W   = 5;
   localparam int RRPV_W      = 2;
   localparam int CTR_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 2;

   localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
   localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd1;
   localparam logic [RRPV_W-1:0] RRPV_HIT     = 2'd0;
   localparam logic [CTR_W-1:0]  CTR_MAX      = 2'd3;
   localparam logic [CTR_W-1:0]  CTR_MIN      = 2'd0;

   localparam int STRIDE_ONE = 64;
   localparam int STRIDE_TWO = 128;

   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_THR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_THR  = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RESET_STREAM_THR = 2'd3;
   localparam logic [CSR_DATA_W-1:0] RESET_REUSE_THR  = 2'd2;

   typedef struct packed {
      logic [MAX_WAY_W-1:0] pick;
      logic                 aging;
   } victim_type;

   typedef struct packed {
      logic             stride;
      logic [CTR_W-1:0] count;
   } stream_type;

   // Reduces a set field modulo the set count by shifted compare and subtract.
   function automatic logic [SET_FIELD_W-1:0] set_reduce(input logic [SET_FIELD_W-1:0] raw,
                                                         input int sets);
      logic [SET_FIELD_W-1:0] r;
      int unsigned            step;
      r = raw;
      for (int k = SET_FIELD_W - 1; k >= 0; k--) begin
         step = int'(sets) << k;
         if (step < (2 ** SET_FIELD_W) && 32'(r) >= step) begin
            r = r - SET_FIELD_W'(step);
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/ship_rrip_streaming_bypass_replacement_core.sv
`timescale 1ns / 1ps
// An accepted item's set row is read into the memory output registers; in the execute
// state the result is loaded into the output register, when it is empty or being taken,
// and any change to the set row is written back; no new item is accepted before that. Reset
// (synchronous, active high) starts a clearing pass writing the reset values into all three memories.
// No item is accepted during the pass; configuration writes are taken at any time.

module ship_rrip_streaming_bypass_replacement_core
   import srrip_pkg::*;
#(
   parameter int NUM_SETS  = DEF_NUM_SETS,
   parameter int NUM_WAYS  = DEF_NUM_WAYS,
   parameter int SIG_BITS  = DEF_SIG_BITS,
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [SET_FIELD_W-1:0] req_set_index,
   input  logic [WAY_FIELD_W-1:0] req_way_index,
   input  logic [ADDR_BITS-1:0]   req_phys_address,
   input  logic [SIG_BITS-1:0]    req_pc_low,
   input  logic                   req_was_hit,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VICTIM_W-1:0]    rsp_victim_way,
   output logic                   rsp_is_victim_reply,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int SIG_DEPTH = 2 ** SIG_BITS;
   localparam int CLR_DEPTH = (NUM_SETS > SIG_DEPTH) ? NUM_SETS : SIG_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int ROW_W     = NUM_WAYS * RRPV_W;
   localparam int STR_W     = ADDR_BITS + CTR_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                state_ff, state_in;
   logic [CLR_W-1:0]         clr_ff, clr_in;
   logic [CTR_W-1:0]         stream_thr_ff, stream_thr_in;
   logic [CTR_W-1:0]         reuse_thr_ff, reuse_thr_in;
   logic                     op_ff, op_in;
   logic [SET_AW-1:0]        set_ff, set_in;
   logic [WAY_FIELD_W-1:0]   way_ff, way_in;
   logic [ADDR_BITS-1:0]     addr_ff, addr_in;
   logic [SIG_BITS-1:0]      sig_ff, sig_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_W-1:0]      rsp_way_ff, rsp_way_in;
   logic                     rsp_victim_ff, rsp_victim_in;

   logic                     accept;
   logic                     finish;
   logic [SET_AW-1:0]        req_set;

   logic                     row_wr_en, row_rd_en;
   logic [SET_AW-1:0]        row_wr_addr;
   logic [ROW_W-1:0]         row_wr_data, row_rd_data, aged_row, upd_row;
   logic                     sig_wr_en;
   logic [SIG_BITS-1:0]      sig_wr_addr;
   logic [CTR_W-1:0]         sig_wr_data, sig_rd_data;
   logic                     str_wr_en;
   logic [SET_AW-1:0]        str_wr_addr;
   logic [STR_W-1:0]         str_wr_data, str_rd_data;

   victim_type               vic;
   stream_type               strm;
   logic                     bypass;
   logic                     way_ok;
   logic [RRPV_W-1:0]        new_lane;
   logic [CTR_W-1:0]         new_reuse;

   srrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (req_set),
      .rd_data (row_rd_data)
   );

   srrip_ram #(.WIDTH(CTR_W), .DEPTH(SIG_DEPTH)) u_sig_ram (
      .clock   (clock),
      .wr_en   (sig_wr_en),
      .wr_addr (sig_wr_addr),
      .wr_data (sig_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (req_pc_low),
      .rd_data (sig_rd_data)
   );

   srrip_ram #(.WIDTH(STR_W), .DEPTH(NUM_SETS)) u_str_ram (
      .clock   (clock),
      .wr_en   (str_wr_en),
      .wr_addr (str_wr_addr),
      .wr_data (str_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (req_set),
      .rd_data (str_rd_data)
   );

   srrip_victim #(.NUM_WAYS(NUM_WAYS)) u_victim (
      .row      (row_rd_data),
      .aged_row (aged_row),
      .result   (vic)
   );

   srrip_stream #(.ADDR_BITS(ADDR_BITS)) u_stream (
      .addr   (addr_ff),
      .last   (str_rd_data[STR_W-1:CTR_W]),
      .count  (str_rd_data[CTR_W-1:0]),
      .result (strm)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_set   = SET_AW'(set_reduce(req_set_index, NUM_SETS));
   assign row_rd_en = accept;

   always_comb begin
      bypass = (strm.count >= stream_thr_ff);
      way_ok = 32'(way_ff) < NUM_WAYS;
      if (bypass) begin
         new_lane = RRPV_DISTANT;
      end else if (hit_ff) begin
         new_lane = RRPV_HIT;
      end else begin
         new_lane = (sig_rd_data >= reuse_thr_ff) ? RRPV_NEAR : RRPV_DISTANT;
      end
      if (hit_ff) begin
         new_reuse = (sig_rd_data == CTR_MAX) ? CTR_MAX : sig_rd_data + 2'd1;
      end else begin
         new_reuse = (sig_rd_data == CTR_MIN) ? CTR_MIN : sig_rd_data - 2'd1;
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         upd_row[w*RRPV_W +: RRPV_W] = (32'(way_ff) == w) ? new_lane
                                                          : row_rd_data[w*RRPV_W +: RRPV_W];
      end

      if (state_ff == ST_CLEAR) begin
         row_wr_en   = 32'(clr_ff) < NUM_SETS;
         row_wr_addr = clr_ff[SET_AW-1:0];
         row_wr_data = {NUM_WAYS{RRPV_DISTANT}};
         sig_wr_en   = 1'b1;
         sig_wr_addr = clr_ff[SIG_BITS-1:0];
         sig_wr_data = CTR_MIN;
         str_wr_en   = 32'(clr_ff) < NUM_SETS;
         str_wr_addr = clr_ff[SET_AW-1:0];
         str_wr_data = '0;
      end else begin
         row_wr_en   = finish && ((op_ff == OP_VICTIM) ? vic.aging : way_ok);
         row_wr_addr = set_ff;
         row_wr_data = (op_ff == OP_VICTIM) ? aged_row : upd_row;
         sig_wr_en   = finish && (op_ff == OP_UPDATE) && !bypass;
         sig_wr_addr = sig_ff;
         sig_wr_data = new_reuse;
         str_wr_en   = finish && (op_ff == OP_UPDATE);
         str_wr_addr = set_ff;
         str_wr_data = {addr_ff, strm.count};
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      stream_thr_in = stream_thr_ff;
      reuse_thr_in  = reuse_thr_ff;
      op_in         = op_ff;
      set_in        = set_ff;
      way_in        = way_ff;
      addr_in       = addr_ff;
      sig_in        = sig_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_way_in    = rsp_way_ff;
      rsp_victim_in = rsp_victim_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_STREAM_THR: stream_thr_in = csr_data;
            CSR_REUSE_THR:  reuse_thr_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               set_in   = req_set;
               way_in   = req_way_index;
               addr_in  = req_phys_address;
               sig_in   = req_pc_low;
               hit_in   = req_was_hit;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               rsp_valid_in  = 1'b1;
               rsp_victim_in = (op_ff == OP_VICTIM);
               rsp_way_in    = (op_ff == OP_VICTIM) ? VICTIM_W'(vic.pick) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         stream_thr_ff <= RESET_STREAM_THR;
         reuse_thr_ff  <= RESET_REUSE_THR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         stream_thr_ff <= stream_thr_in;
         reuse_thr_ff  <= reuse_thr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      set_ff        <= set_in;
      way_ff        <= way_in;
      addr_ff       <= addr_in;
      sig_ff        <= sig_in;
      hit_ff        <= hit_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_victim_way      = rsp_way_ff;
   assign rsp_is_victim_reply = rsp_victim_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted item did not enter execution");

   a_update_way_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_victim_reply |-> rsp_victim_way == '0)
      else $error("update acknowledge carries a nonzero way");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !row_wr_en && !sig_wr_en && !str_wr_en)
      else $error("memory write while idle");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid && state_ff == ST_IDLE)
      else $error("finished item did not reach the output register");

endmodule

FILE: hdl/srrip_ram.sv
`timescale 1ns / 1ps

module srrip_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/srrip_victim.sv
`timescale 1ns / 1ps

module srrip_victim
   import srrip_pkg::*;
#(
   parameter int NUM_WAYS = DEF_NUM_WAYS
) (
   input  logic [NUM_WAYS*RRPV_W-1:0] row,
   output logic [NUM_WAYS*RRPV_W-1:0] aged_row,
   output victim_type                 result
);

   logic [RRPV_W-1:0] top;
   logic [RRPV_W-1:0] age;
   logic              any3;
   logic              any2;
   logic              any1;
   logic              found;

   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         any3 = any3 | (row[w*RRPV_W +: RRPV_W] == 2'd3);
         any2 = any2 | (row[w*RRPV_W +: RRPV_W] == 2'd2);
         any1 = any1 | (row[w*RRPV_W +: RRPV_W] == 2'd1);
      end
      top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
      age = RRPV_DISTANT - top;

      found       = 1'b0;
      result.pick = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged_row[w*RRPV_W +: RRPV_W] = row[w*RRPV_W +: RRPV_W] + age;
         if (!found && row[w*RRPV_W +: RRPV_W] == top) begin
            found       = 1'b1;
            result.pick = MAX_WAY_W'(w);
         end
      end
      result.aging = (top != RRPV_DISTANT);
   end

endmodule

FILE: hdl/srrip_stream.sv
`timescale 1ns / 1ps

module srrip_stream
   import srrip_pkg::*;
#(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [ADDR_BITS-1:0] last,
   input  logic [CTR_W-1:0]     count,
   output stream_type           result
);

   localparam int DW = ADDR_BITS + 1;
   localparam logic [DW-1:0] POS_ONE = DW'(STRIDE_ONE);
   localparam logic [DW-1:0] POS_TWO = DW'(STRIDE_TWO);
   localparam logic [DW-1:0] NEG_ONE = DW'(0) - POS_ONE;
   localparam logic [DW-1:0] NEG_TWO = DW'(0) - POS_TWO;

   logic [DW-1:0] diff;

   always_comb begin
      diff = {1'b0, addr} - {1'b0, last};
      result.stride = (last != '0) &&
                      (diff == POS_ONE || diff == NEG_ONE || diff == POS_TWO || diff == NEG_TWO);
      if (result.stride) begin
         result.count = (count == CTR_MAX) ? CTR_MAX : count + 2'd1;
      end else begin
         result.count = (count == CTR_MIN) ? CTR_MIN : count - 2'd1;
      end
   end

endmodule

FILE: tb/ship_rrip_streaming_bypass_replacement_core_test.sv
`timescale 1ns / 1ps

module ship_rrip_streaming_bypass_replacement_core_test;
   import srrip_pkg::*;

   localparam int HOT_SETS = 6;
   localparam int HOT_PCS  = 8;

   typedef struct {
      logic                     operation;
      logic [SET_FIELD_W-1:0]   set_index;
      logic [WAY_FIELD_W-1:0]   way_index;
      logic [DEF_ADDR_BITS-1:0] phys_address;
      logic [DEF_SIG_BITS-1:0]  pc_low;
      logic                     was_hit;
   } access_type;

   typedef struct {
      logic [VICTIM_W-1:0] victim_way;
      logic                is_victim_reply;
   } reply_type;

   class rrip_policy_tracker;
      logic [RRPV_W-1:0]        rrpv [DEF_NUM_SETS][DEF_NUM_WAYS];
      logic [CTR_W-1:0]         reuse_ctr [1 << DEF_SIG_BITS];
      logic [DEF_ADDR_BITS-1:0] prev_address [DEF_NUM_SETS];
      logic [CTR_W-1:0]         stride_level [DEF_NUM_SETS];
      logic [CSR_DATA_W-1:0]    stream_thr;
      logic [CSR_DATA_W-1:0]    reuse_thr;
      reply_type                expected_replies [$];
      int                       mismatches;

      function new();
         foreach (rrpv[s, w]) rrpv[s][w] = RRPV_DISTANT;
         foreach (reuse_ctr[i]) reuse_ctr[i] = CTR_MIN;
         foreach (prev_address[i]) prev_address[i] = '0;
         foreach (stride_level[i]) stride_level[i] = CTR_MIN;
         stream_thr = RESET_STREAM_THR;
         reuse_thr  = RESET_REUSE_THR;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_STREAM_THR) begin
            stream_thr = value;
         end else if (idx == CSR_REUSE_THR) begin
            reuse_thr = value;
         end
      endfunction

      function void note_access(access_type a);
         reply_type                r;
         int                       set_no;
         logic [RRPV_W-1:0]        top;
         logic [DEF_ADDR_BITS-1:0] stride;
         set_no = int'(a.set_index) % DEF_NUM_SETS;
         r.victim_way = '0;
         r.is_victim_reply = 1'b0;
         if (a.operation == OP_VICTIM) begin
            top = '0;
            for (int w = 0; w < DEF_NUM_WAYS; w++) begin
               if (rrpv[set_no][w] > top) top = rrpv[set_no][w];
            end
            for (int w = 0; w < DEF_NUM_WAYS; w++) begin
               rrpv[set_no][w] = rrpv[set_no][w] + (RRPV_DISTANT - top);
            end
            for (int w = DEF_NUM_WAYS - 1; w >= 0; w--) begin
               if (rrpv[set_no][w] == RRPV_DISTANT) r.victim_way = VICTIM_W'(w);
            end
            r.is_victim_reply = 1'b1;
         end else begin
            stride = (a.phys_address > prev_address[set_no])
                     ? a.phys_address - prev_address[set_no]
                     : prev_address[set_no] - a.phys_address;
            if (prev_address[set_no] != '0 && (stride == STRIDE_ONE || stride == STRIDE_TWO))
            begin
               if (stride_level[set_no] != CTR_MAX) begin
                  stride_level[set_no] = stride_level[set_no] + 1'b1;
               end
            end else if (stride_level[set_no] != CTR_MIN) begin
               stride_level[set_no] = stride_level[set_no] - 1'b1;
            end
            prev_address[set_no] = a.phys_address;
            if (stride_level[set_no] >= stream_thr) begin
               rrpv[set_no][a.way_index] = RRPV_DISTANT;
            end else if (a.was_hit) begin
               rrpv[set_no][a.way_index] = RRPV_HIT;
               if (reuse_ctr[a.pc_low] != CTR_MAX) reuse_ctr[a.pc_low] = reuse_ctr[a.pc_low] + 1'b1;
            end else begin
               rrpv[set_no][a.way_index] = (reuse_ctr[a.pc_low] >= reuse_thr) ? RRPV_NEAR
                                                                                : RRPV_DISTANT;
               if (reuse_ctr[a.pc_low] != CTR_MIN) reuse_ctr[a.pc_low] = reuse_ctr[a.pc_low] - 1'b1;
            end
         end
         expected_replies.push_back(r);
      endfunction

      function void report(string what, logic [VICTIM_W-1:0] want, logic [VICTIM_W-1:0] got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         end
      endfunction

      function void check_reply(logic [VICTIM_W-1:0] way, logic is_victim);
         reply_type e;
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: reply with no access outstanding, way %0d", $time, way);
            end
            return;
         end
         e = expected_replies.pop_front();
         if (is_victim !== e.is_victim_reply) begin
            report("is_victim_reply", VICTIM_W'(e.is_victim_reply), VICTIM_W'(is_victim));
         end
         if (way !== e.victim_way) report("victim_way", e.victim_way, way);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_operation = 1'b0;
   logic [SET_FIELD_W-1:0]   req_set_index = '0;
   logic [WAY_FIELD_W-1:0]   req_way_index = '0;
   logic [DEF_ADDR_BITS-1:0] req_phys_address = '0;
   logic [DEF_SIG_BITS-1:0]  req_pc_low = '0;
   logic                     req_was_hit = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [VICTIM_W-1:0]      rsp_victim_way;
   logic                     rsp_is_victim_reply;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   rrip_policy_tracker       tracker;
   int                       accesses_sent = 0;
   int                       receiver_hold = 0;
   bit                       no_idle = 1'b0;
   logic [SET_FIELD_W-1:0]   hot_set [HOT_SETS];
   logic [DEF_ADDR_BITS-1:0] hot_addr [HOT_SETS];
   logic [DEF_SIG_BITS-1:0]  hot_pc [HOT_PCS];

   ship_rrip_streaming_bypass_replacement_core uut (.*);

   always #5 clock = ~clock;

   function automatic access_type any_access();
      access_type a;
      a.operation    = 1'($urandom_range(0, 1));
      a.set_index    = SET_FIELD_W'($urandom);
      a.way_index    = WAY_FIELD_W'($urandom);
      a.phys_address = DEF_ADDR_BITS'({$urandom, $urandom});
      a.pc_low       = DEF_SIG_BITS'($urandom);
      a.was_hit      = 1'($urandom_range(0, 1));
      return a;
   endfunction

   function automatic access_type make_access(logic op, int set_no, int way,
                                              logic [DEF_ADDR_BITS-1:0] addr, int pc,
                                              logic hit);
      access_type a;
      a.operation    = op;
      a.set_index    = SET_FIELD_W'(set_no);
      a.way_index    = WAY_FIELD_W'(way);
      a.phys_address = addr;
      a.pc_low       = DEF_SIG_BITS'(pc);
      a.was_hit      = hit;
      return a;
   endfunction

   task automatic send_access(access_type a);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= a.operation;
      req_set_index    <= a.set_index;
      req_way_index    <= a.way_index;
      req_phys_address <= a.phys_address;
      req_pc_low       <= a.pc_low;
      req_was_hit      <= a.was_hit;
      do @(posedge clock); while (!req_ready);
      tracker.note_access(a);
      accesses_sent++;
   endtask

   task automatic await_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_replies.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, value);
   endtask

   task automatic start_phase(logic [CSR_DATA_W-1:0] stream_level,
                              logic [CSR_DATA_W-1:0] reuse_level);
      await_idle();
      write_reg(CSR_STREAM_THR, stream_level);
      write_reg(CSR_REUSE_THR, reuse_level);
      csr_valid <= 1'b0;
   endtask

   task automatic stream_run(int k);
      access_type a;
      int         len;
      int         step;
      len = $urandom_range(3, 10);
      for (int i = 0; i < len; i++) begin
         a = any_access();
         a.set_index = hot_set[k];
         a.pc_low = hot_pc[$urandom_range(0, HOT_PCS - 1)];
         a.operation = ($urandom_range(0, 5) == 0) ? OP_VICTIM : OP_UPDATE;
         if (a.operation == OP_UPDATE) begin
            case ($urandom_range(0, 9))
               0: hot_addr[k] = DEF_ADDR_BITS'({$urandom, $urandom});
               1: hot_addr[k] = hot_addr[k] + DEF_ADDR_BITS'($urandom_range(0, 7) * 32);
               default: begin
                  step = $urandom_range(0, 1) ? STRIDE_ONE : STRIDE_TWO;
                  if ($urandom_range(0, 1)) hot_addr[k] = hot_addr[k] + DEF_ADDR_BITS'(step);
                  else hot_addr[k] = hot_addr[k] - DEF_ADDR_BITS'(step);
               end
            endcase
         end
         a.phys_address = hot_addr[k];
         send_access(a);
      end
   endtask

   // Touches every way of a set without a stride so that the set can fall below
   // the distant value everywhere, then asks for victims to force aging.
   task automatic warm_set(int k);
      access_type a;
      bit         all_hits;
      all_hits = 1'($urandom_range(0, 1));
      for (int w = 0; w < DEF_NUM_WAYS + 3; w++) begin
         a = any_access();
         a.operation = OP_UPDATE;
         a.set_index = hot_set[k];
         a.way_index = WAY_FIELD_W'(w % DEF_NUM_WAYS);
         a.pc_low = hot_pc[$urandom_range(0, HOT_PCS - 1)];
         a.was_hit = all_hits || ($urandom_range(0, 3) != 0);
         hot_addr[k] = a.phys_address;
         send_access(a);
      end
      repeat ($urandom_range(1, 3)) begin
         a = any_access();
         a.operation = OP_VICTIM;
         a.set_index = hot_set[k];
         send_access(a);
      end
   endtask

   task automatic random_phase(int count);
      access_type a;
      int         goal;
      goal = accesses_sent + count;
      while (accesses_sent < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: stream_run($urandom_range(0, HOT_SETS - 1));
            4, 5: warm_set($urandom_range(0, HOT_SETS - 1));
            6, 7, 8: begin
               repeat (3) begin
                  a = any_access();
                  a.set_index = hot_set[$urandom_range(0, HOT_SETS - 1)];
                  a.pc_low = hot_pc[$urandom_range(0, HOT_PCS - 1)];
                  send_access(a);
               end
            end
            default: begin
               send_access(any_access());
               hot_set[$urandom_range(0, HOT_SETS - 1)] = SET_FIELD_W'($urandom);
            end
         endcase
      end
   endtask

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin : reply_side
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (receiver_hold > 0) begin
            stall = receiver_hold;
            receiver_hold = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_reply(rsp_victim_way, rsp_is_victim_reply);
      end
   end

   initial begin : access_side
      logic [DEF_ADDR_BITS-1:0] top_addr;
      int                       wait_cycles;
      tracker = new();
      top_addr = '1;
      foreach (hot_set[k]) begin
         hot_set[k] = SET_FIELD_W'($urandom);
         hot_addr[k] = DEF_ADDR_BITS'({$urandom, $urandom});
      end
      foreach (hot_pc[k]) hot_pc[k] = DEF_SIG_BITS'($urandom);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      start_phase(RESET_STREAM_THR, RESET_REUSE_THR);
      send_access(make_access(OP_VICTIM, 0, 0, '0, 0, 1'b0));
      send_access(make_access(OP_VICTIM, DEF_NUM_SETS - 1, 0, '0, 0, 1'b0));
      // A stride measured from a zero last address does not count.
      send_access(make_access(OP_UPDATE, 0, 15, '0, 0, 1'b1));
      send_access(make_access(OP_UPDATE, 0, 0, DEF_ADDR_BITS'(64), 0, 1'b1));
      send_access(make_access(OP_UPDATE, 0, 1, DEF_ADDR_BITS'(128), 0, 1'b1));
      send_access(make_access(OP_UPDATE, 0, 2, DEF_ADDR_BITS'(256), 0, 1'b1));
      send_access(make_access(OP_UPDATE, 0, 3, DEF_ADDR_BITS'(192), 0, 1'b1));
      send_access(make_access(OP_UPDATE, 0, 4, DEF_ADDR_BITS'(1000), 0, 1'b0));
      send_access(make_access(OP_VICTIM, 0, 0, '0, 0, 1'b0));
      send_access(make_access(OP_UPDATE, 1, 5, top_addr, 4095, 1'b0));
      send_access(make_access(OP_UPDATE, 1, 6, top_addr - DEF_ADDR_BITS'(128), 4095, 1'b1));
      send_access(make_access(OP_UPDATE, 1, 7, top_addr - DEF_ADDR_BITS'(64), 4095, 1'b1));
      send_access(make_access(OP_UPDATE, 1, 8, top_addr, 4095, 1'b0));
      send_access(make_access(OP_VICTIM, 1, 0, '0, 0, 1'b0));
      start_phase(2'd0, 2'd0);
      send_access(make_access(OP_UPDATE, DEF_NUM_SETS - 1, 15, top_addr, 2048, 1'b1));
      send_access(make_access(OP_VICTIM, DEF_NUM_SETS - 1, 0, '0, 0, 1'b0));
      start_phase(2'd3, 2'd3);
      send_access(make_access(OP_UPDATE, 2, 9, DEF_ADDR_BITS'(4096), 0, 1'b0));
      send_access(make_access(OP_UPDATE, 2, 10, DEF_ADDR_BITS'(8192), 0, 1'b1));
      send_access(make_access(OP_VICTIM, 2, 0, '0, 0, 1'b0));

      start_phase(2'd3, 2'd2);
      receiver_hold = 150;
      random_phase(213);
      start_phase(2'd0, 2'd0);
      random_phase(213);
      start_phase(2'd3, 2'd3);
      no_idle = 1'b1;
      random_phase(100);
      no_idle = 1'b0;
      random_phase(113);
      start_phase(2'd1, 2'd1);
      random_phase(100);
      await_idle();
      random_phase(113);
      start_phase(2'd2, 2'd3);
      random_phase(213);
      start_phase(2'd3, 2'd0);
      random_phase(213);

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (tracker.expected_replies.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (tracker.expected_replies.size() != 0) begin
         $display("%0d expected replies never arrived", tracker.expected_replies.size());
         tracker.mismatches += tracker.expected_replies.size();
      end
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
